>>> rtl/core/bdq_pkg.sv
// bdq_pkg: command, status and cell operation codes for the deque unit
// no dependencies; imported by bdq_cell, bounded_deque_with_value_remove_unit and the test bench
package bdq_pkg;

    typedef logic [2:0] t_cmd;
    typedef logic [1:0] t_status;
    typedef logic [2:0] t_cell_op;

    // command codes carried on the input tuser
    localparam t_cmd CMD_INS_FRONT = 3'd0;
    localparam t_cmd CMD_INS_BACK  = 3'd1;
    localparam t_cmd CMD_REM_FRONT = 3'd2;
    localparam t_cmd CMD_REM_BACK  = 3'd3;
    localparam t_cmd CMD_REM_VALUE = 3'd4;

    // result status codes
    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_EMPTY     = 2'd1;
    localparam t_status ST_FULL      = 2'd2;
    localparam t_status ST_NOT_FOUND = 2'd3;

    // per-cell update operations
    localparam t_cell_op OP_HOLD      = 3'd0;
    localparam t_cell_op OP_SHIFT_IN  = 3'd1; // take the left neighbor
    localparam t_cell_op OP_PUT_TAIL  = 3'd2; // write word if first free cell
    localparam t_cell_op OP_SHIFT_OUT = 3'd3; // take the right neighbor
    localparam t_cell_op OP_CLOSE_GAP = 3'd4; // take the right neighbor at or past a match

endpackage

>>> rtl/core/bdq_cell.sv
// bdq_cell: one storage cell of the deque chain, holds one word
// compares against the search word and shifts to/from its neighbors; uses bdq_pkg
module bdq_cell
    import bdq_pkg::*;
#(
    parameter int WORD_BITS  = 32,
    parameter int COUNT_BITS = 5,
    parameter int IDX        = 0
) (
    input  logic                  i_clk,
    input  t_cell_op              i_op,
    input  logic [WORD_BITS-1:0]  i_word,
    input  logic [COUNT_BITS-1:0] i_count,
    input  logic [WORD_BITS-1:0]  i_left_data,
    input  logic [WORD_BITS-1:0]  i_right_data,
    input  logic                  i_found,
    output logic                  o_found,
    output logic [WORD_BITS-1:0]  o_data,
    output logic [WORD_BITS-1:0]  o_tail_word
);

    logic [WORD_BITS-1:0] r_data;
    logic [WORD_BITS-1:0] n_data;
    logic                 w_occupied;
    logic                 w_is_free_head;
    logic                 w_is_last;

    assign w_occupied     = COUNT_BITS'(IDX) < i_count;
    assign w_is_free_head = i_count == COUNT_BITS'(IDX);
    assign w_is_last      = i_count == COUNT_BITS'(IDX + 1);

    // match chain: high from the first matching cell onward
    assign o_found     = i_found | (w_occupied & (r_data == i_word));
    assign o_tail_word = w_is_last ? r_data : '0;
    assign o_data      = r_data;

    always_comb begin
        n_data = r_data;
        case (i_op)
            OP_SHIFT_IN:  n_data = i_left_data;
            OP_PUT_TAIL:  if (w_is_free_head) n_data = i_word;
            OP_SHIFT_OUT: n_data = i_right_data;
            OP_CLOSE_GAP: if (o_found) n_data = i_right_data;
            default:      n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

endmodule

>>> rtl/core/bounded_deque_with_value_remove_unit.sv
// bounded_deque_with_value_remove_unit: bounded deque with remove-by-value
// top level; a chain of bdq_cell instances plus count and result register; uses bdq_pkg
//
//   channel | dir | handshake           | payload
//   s       | in  | i_s_tvalid/o_s_tready | tdata: word_in; tuser: command
//   m       | out | o_m_tvalid/i_m_tready | tdata: word_out, entry_count;
//           |     |                       | tuser: status, is_empty
//
// one command per cycle unless the sink stalls; result shows the cycle after its beat
// the cell chain updates every entry in the same cycle; the first-match search
// is a ripple through the cells, DEPTH cells long
// a new beat is taken while the held result is being taken by the sink
// synchronous active-low reset empties the store and drops any held result
// stored words are not cleared; only entries below the count are ever read
module bounded_deque_with_value_remove_unit
    import bdq_pkg::*;
#(
    parameter int DEPTH     = 16,
    parameter int WORD_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [((WORD_BITS + 7) / 8) * 8 - 1:0] i_s_tdata,  // word_in
    input  logic [2:0]           i_s_tuser,  // command
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // word_out, entry_count
    output logic [((WORD_BITS + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0] o_m_tdata,
    output logic [2:0]           o_m_tuser   // status, is_empty
);

    localparam int CW       = $clog2(DEPTH + 1);
    localparam int OUT_BITS = ((WORD_BITS + CW + 7) / 8) * 8;

    logic [CW-1:0]        r_count;
    logic [CW-1:0]        n_count;
    logic                 r_out_valid;
    logic [WORD_BITS-1:0] r_word;
    logic [WORD_BITS-1:0] n_word;
    t_status              r_status;
    t_status              n_status;
    logic [CW-1:0]        r_count_out;
    logic                 r_empty_out;

    logic                 w_accept;
    logic                 w_full;
    logic                 w_empty;
    t_cmd                 w_cmd;
    logic [WORD_BITS-1:0] w_word;
    t_cell_op             w_op;
    t_cell_op             w_cell_op;
    logic [WORD_BITS-1:0] w_tail_word;

    logic [WORD_BITS-1:0] w_data      [DEPTH];
    logic [WORD_BITS-1:0] w_tail_part [DEPTH];
    logic [DEPTH:0]       w_found;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_cmd      = i_s_tuser;
    assign w_word     = i_s_tdata[WORD_BITS-1:0];
    assign w_full     = r_count == CW'(DEPTH);
    assign w_empty    = r_count == '0;
    assign w_found[0] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic [WORD_BITS-1:0] w_left;
            logic [WORD_BITS-1:0] w_right;
            if (gi == 0) begin : g_head
                assign w_left = w_word;
            end else begin : g_mid_l
                assign w_left = w_data[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_end
                assign w_right = w_data[gi];
            end else begin : g_mid_r
                assign w_right = w_data[gi+1];
            end
            bdq_cell #(
                .WORD_BITS  (WORD_BITS),
                .COUNT_BITS (CW),
                .IDX        (gi)
            ) u_cell (
                .i_clk        (i_clk),
                .i_op         (w_cell_op),
                .i_word       (w_word),
                .i_count      (r_count),
                .i_left_data  (w_left),
                .i_right_data (w_right),
                .i_found      (w_found[gi]),
                .o_found      (w_found[gi+1]),
                .o_data       (w_data[gi]),
                .o_tail_word  (w_tail_part[gi])
            );
        end
    endgenerate

    // only the last occupied cell drives a nonzero tail word
    always_comb begin
        w_tail_word = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_tail_word = w_tail_word | w_tail_part[i];
        end
    end

    always_comb begin
        w_op     = OP_HOLD;
        n_count  = r_count;
        n_word   = '0;
        n_status = ST_OK;
        case (w_cmd)
            CMD_INS_FRONT: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_op    = OP_SHIFT_IN;
                    n_count = r_count + 1'b1;
                end
            end
            CMD_INS_BACK: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_op    = OP_PUT_TAIL;
                    n_count = r_count + 1'b1;
                end
            end
            CMD_REM_FRONT: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    w_op    = OP_SHIFT_OUT;
                    n_word  = w_data[0];
                    n_count = r_count - 1'b1;
                end
            end
            CMD_REM_BACK: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_word  = w_tail_word;
                    n_count = r_count - 1'b1;
                end
            end
            CMD_REM_VALUE: begin
                if (w_found[DEPTH]) begin
                    // the removed entry equals the search word
                    w_op    = OP_CLOSE_GAP;
                    n_word  = w_word;
                    n_count = r_count - 1'b1;
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            default: begin
                w_op = OP_HOLD;
            end
        endcase
    end

    assign w_cell_op = w_accept ? w_op : OP_HOLD;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_word      <= n_word;
            r_status    <= n_status;
            r_count_out <= n_count;
            r_empty_out <= n_count == '0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_BITS'({r_count_out, r_word});
    assign o_m_tuser  = {r_empty_out, r_status};

endmodule

>>> verif/bounded_deque_with_value_remove_unit_test.sv
`timescale 1ns / 1ps
// bounded_deque_with_value_remove_unit_test: self-checking bench for the deque unit
// command beats are driven from a queue; each result is checked against a queue-based deque model
// depends on bdq_pkg and bounded_deque_with_value_remove_unit
module bounded_deque_with_value_remove_unit_test;
    import bdq_pkg::*;

    localparam int DEPTH            = 16;
    localparam int WORD_BITS        = 32;
    localparam int IN_BITS          = 32;
    localparam int OUT_BITS         = 40;
    localparam int STALL_LIMIT      = 2000;
    localparam int RANDOM_PER_PHASE = 510;
    localparam int TAIL_CYCLES      = 4;

    typedef struct packed {
        t_cmd        cmd;
        logic [31:0] word;
    } t_command_beat;

    typedef struct packed {
        logic [31:0] word;
        t_status     status;
        logic [4:0]  count;
        logic        empty;
    } t_deque_result;

    logic                i_clk      = 1'b0;
    logic                i_rst_n    = 1'b0;
    logic                i_s_tvalid = 1'b0;
    logic                o_s_tready;
    logic [IN_BITS-1:0]  i_s_tdata  = '0;   // word_in
    logic [2:0]          i_s_tuser  = '0;   // command
    logic                o_m_tvalid;
    logic                i_m_tready = 1'b0;
    logic [OUT_BITS-1:0] o_m_tdata;         // word_out, entry_count, zero pad
    logic [2:0]          o_m_tuser;         // status, is_empty

    t_command_beat pending_cmds[$];
    t_deque_result expected_results[$];
    logic [31:0]   model_words[$];          // front of the deque at index 0
    logic [31:0]   word_pool[8];
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;
    int            mismatches    = 0;
    int            stall_cycles  = 0;
    logic          cmd_taken     = 1'b0;

    bounded_deque_with_value_remove_unit #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_deque_result apply_deque_command(t_command_beat beat);
        t_deque_result r;
        bit            hit;
        r        = '0;
        r.status = ST_OK;
        hit      = 1'b0;
        case (beat.cmd)
            CMD_INS_FRONT, CMD_INS_BACK: begin
                if (model_words.size() >= DEPTH)
                    r.status = ST_FULL;
                else if (beat.cmd == CMD_INS_FRONT)
                    model_words.push_front(beat.word);
                else
                    model_words.push_back(beat.word);
            end
            CMD_REM_FRONT: begin
                if (model_words.size() == 0)
                    r.status = ST_EMPTY;
                else
                    r.word = model_words.pop_front();
            end
            CMD_REM_BACK: begin
                if (model_words.size() == 0)
                    r.status = ST_EMPTY;
                else
                    r.word = model_words.pop_back();
            end
            CMD_REM_VALUE: begin
                r.status = ST_NOT_FOUND;
                // first match from the front; later entries close up
                for (int i = 0; i < model_words.size(); i++) begin
                    if (!hit && model_words[i] == beat.word) begin
                        hit      = 1'b1;
                        r.word   = model_words[i];
                        r.status = ST_OK;
                        model_words.delete(i);
                    end
                end
            end
            default: begin
            end
        endcase
        r.count = 5'(model_words.size());
        r.empty = (model_words.size() == 0);
        return r;
    endfunction

    task automatic queue_command(t_cmd cmd, logic [31:0] word);
        t_command_beat beat;
        beat.cmd  = cmd;
        beat.word = word;
        pending_cmds.push_back(beat);
    endtask

    // runs of 40 beats lean toward filling, draining or neither so both bounds get hit
    task automatic add_random_commands(int n);
        t_command_beat beat;
        int            ins_weight;
        ins_weight = 50;
        for (int k = 0; k < n; k++) begin
            if (k % 40 == 0) begin
                case ($urandom_range(0, 2))
                    0:       ins_weight = 75;
                    1:       ins_weight = 25;
                    default: ins_weight = 50;
                endcase
            end
            beat.word = $urandom_range(0, 1) ? word_pool[$urandom_range(0, 7)] : $urandom;
            if ($urandom_range(0, 99) < ins_weight) begin
                beat.cmd = $urandom_range(0, 1) ? CMD_INS_FRONT : CMD_INS_BACK;
            end else begin
                case ($urandom_range(0, 2))
                    0:       beat.cmd = CMD_REM_FRONT;
                    1:       beat.cmd = CMD_REM_BACK;
                    default: beat.cmd = CMD_REM_VALUE;
                endcase
            end
            pending_cmds.push_back(beat);
        end
    endtask

    // driver: new values at the falling edge
    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || cmd_taken) begin
            if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= pending_cmds[0].word;
                i_s_tuser  <= pending_cmds[0].cmd;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // monitor and scoreboard: sample at the rising edge
    always @(posedge i_clk) begin : monitor
        t_deque_result got;
        t_deque_result want;
        bit            in_beat;
        bit            out_beat;
        in_beat  = i_rst_n && i_s_tvalid && o_s_tready;
        out_beat = i_rst_n && o_m_tvalid && i_m_tready;
        cmd_taken <= in_beat;
        if (out_beat) begin
            got.word   = o_m_tdata[31:0];
            got.count  = o_m_tdata[36:32];
            got.status = o_m_tuser[1:0];
            got.empty  = o_m_tuser[2];
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: word %h status %0d count %0d empty %0b",
                             got.word, got.status, got.count, got.empty);
            end else begin
                want = expected_results.pop_front();
                if (got.word !== want.word || got.status !== want.status ||
                    got.count !== want.count || got.empty !== want.empty) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $write("result mismatch at %0t: expected word %h status %0d ",
                               $realtime, want.word, want.status);
                        $write("count %0d empty %0b, ", want.count, want.empty);
                        $display("got word %h status %0d count %0d empty %0b",
                                 got.word, got.status, got.count, got.empty);
                    end
                end
            end
        end
        if (in_beat)
            expected_results.push_back(apply_deque_command(pending_cmds.pop_front()));
        if (in_beat || out_beat)
            stall_cycles = 0;
        else if (pending_cmds.size() > 0 || expected_results.size() > 0)
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        word_pool[0] = 32'h0000_0000;
        word_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < 8; i++)
            word_pool[i] = $urandom;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int p = 0; p < 3; p++) begin
            send_idle_pct = (p == 0) ? 33 : (p == 1) ? 70 : 0;
            recv_idle_pct = (p == 0) ? 70 : (p == 1) ? 33 : 0;
            if (p == 0) begin
                // removes on an empty store, then inserts and value removes that miss and hit
                queue_command(CMD_REM_FRONT, 32'h0);
                queue_command(CMD_REM_BACK, 32'h0);
                queue_command(CMD_REM_VALUE, 32'h0);
                queue_command(CMD_INS_BACK, 32'h0000_0000);
                queue_command(CMD_INS_FRONT, 32'hFFFF_FFFF);
                queue_command(CMD_REM_VALUE, 32'h1234_5678);
                queue_command(CMD_REM_VALUE, 32'h0000_0000);
                queue_command(CMD_REM_BACK, 32'h0);
                // fill with duplicates, then inserts into a full store and removes by value and from the front
                for (int i = 0; i < DEPTH; i++)
                    queue_command(CMD_INS_BACK, (i % 2 == 0) ? 32'hA5A5_A5A5 : 32'h5A5A_5A00 + i);
                queue_command(CMD_INS_FRONT, 32'hDEAD_BEEF);
                queue_command(CMD_INS_BACK, 32'hDEAD_BEEF);
                queue_command(CMD_REM_VALUE, 32'h5A5A_5A0F);
                queue_command(CMD_REM_VALUE, 32'hA5A5_A5A5);
                queue_command(CMD_REM_FRONT, 32'h0);
            end
            add_random_commands(RANDOM_PER_PHASE);
            // the next phase waits until every command of this phase is sent and its result is back
            while (pending_cmds.size() > 0 || expected_results.size() > 0)
                @(posedge i_clk);
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
